@@ src/assert_macros.svh @@
// Assertion helpers used by wsm_back; they use clk and rst from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define WSM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define WSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/wsm_pkg.sv @@
package wsm_pkg;

  // Pattern store capacity and derived widths
  localparam int PATTERN_LEN = 32;
  localparam int CNT_W       = $clog2(PATTERN_LEN + 1);
  localparam int IDX_W       = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] STAR_BYTE = 8'd42;

  // Input opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_EMPTY  = 2'd3;

  // Register index of the configuration port
  localparam logic REG_IGNORE_CASE = 1'b0;

  // Work kinds after classification
  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_APPEND,
    KIND_TEXT,
    KIND_TEXT_LAST,
    KIND_EVAL_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
  } item_t;

endpackage

@@ src/wsm_front.sv @@
module wsm_front
  import wsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  byte_value,
  input  logic        is_last,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t             queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  item_t             cls_item;
  logic              push;
  logic              pop;

  // Classify the incoming transaction
  always_comb begin
    cls_item.byte_value = byte_value;
    unique case (opcode)
      OP_CLEAR:  cls_item.kind = KIND_CLEAR;
      OP_APPEND: cls_item.kind = KIND_APPEND;
      OP_TEXT:   cls_item.kind = is_last ? KIND_TEXT_LAST : KIND_TEXT;
      OP_EMPTY:  cls_item.kind = KIND_EVAL_EMPTY;
      default:   cls_item.kind = KIND_EVAL_EMPTY;
    endcase
  end

  assign in_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Store classified work
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= QCNT_W'(fill + 1'b1);
      end else if (pop && !push) begin
        fill <= QCNT_W'(fill - 1'b1);
      end
    end
  end

endmodule

@@ src/wsm_back.sv @@
`include "assert_macros.svh"

module wsm_back
  import wsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        ignore_case,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic        out_overflow
);

  // Pattern store: byte plus star flag per position
  logic [7:0]             pat_byte [PATTERN_LEN];
  logic [PATTERN_LEN-1:0] pat_star;

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_inc;
  logic [PATTERN_LEN:0]   active;
  logic [PATTERN_LEN:0]   start;
  logic                   text_open;
  logic                   overflow_seen;

  logic                   take;
  logic                   emit;
  logic [PATTERN_LEN-1:0] used;
  logic [PATTERN_LEN:0]   upto_count;
  logic [PATTERN_LEN-1:0] star_m;
  logic [PATTERN_LEN:0]   base;
  logic [7:0]             tc;
  logic [PATTERN_LEN-1:0] hit;
  logic [PATTERN_LEN-1:0] keep;
  logic [PATTERN_LEN:0]   next_raw;
  logic [PATTERN_LEN:0]   gen_ext;
  logic [PATTERN_LEN:0]   star_ext;
  logic [PATTERN_LEN:0]   sum;
  logic [PATTERN_LEN:0]   adv;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    if (ic && c >= 8'd65 && c <= 8'd90) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  assign take      = q_valid && q_ready;
  assign q_ready   = !out_valid || out_ready;
  assign count_inc = CNT_W'(count + 1'b1);
  assign emit      = take && (q_item.kind == KIND_TEXT_LAST || q_item.kind == KIND_EVAL_EMPTY);

  // Position masks from the fill count
  always_comb begin
    for (int i = 0; i < PATTERN_LEN; i++) begin
      used[i] = (CNT_W'(i) < count);
    end
    for (int i = 0; i <= PATTERN_LEN; i++) begin
      upto_count[i] = (CNT_W'(i) <= count);
    end
  end

  assign star_m = pat_star & used;
  assign base   = text_open ? active : start;
  assign tc     = fold(q_item.byte_value, ignore_case);

  // Step every active position on the text byte
  always_comb begin
    for (int i = 0; i < PATTERN_LEN; i++) begin
      keep[i] = base[i] && star_m[i];
      hit[i]  = base[i] && used[i] && !pat_star[i] &&
                (fold(pat_byte[i], ignore_case) == tc);
    end
  end

  assign next_raw = {hit, 1'b0} | {1'b0, keep};

  // Star closure: a run of stars passes activity upward like a carry chain
  assign gen_ext  = {1'b0, next_raw[PATTERN_LEN-1:0] & star_m};
  assign star_ext = {1'b0, star_m};
  assign sum      = gen_ext + star_ext;
  assign adv      = next_raw | (sum ^ gen_ext ^ star_ext);

  // Pattern store writes
  always_ff @(posedge clk) begin
    if (take && q_item.kind == KIND_APPEND && count < CNT_W'(PATTERN_LEN)) begin
      pat_byte[count[IDX_W-1:0]] <= q_item.byte_value;
      pat_star[count[IDX_W-1:0]] <= (q_item.byte_value == STAR_BYTE);
    end
  end

  // Matcher state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      active        <= '0;
      start         <= (PATTERN_LEN + 1)'(1);
      text_open     <= 1'b0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Raise the result on a new verdict, drop it once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        unique case (q_item.kind)
          KIND_CLEAR: begin
            count         <= '0;
            active        <= '0;
            start         <= (PATTERN_LEN + 1)'(1);
            text_open     <= 1'b0;
            overflow_seen <= 1'b0;
          end
          KIND_APPEND: begin
            text_open <= 1'b0;
            if (count < CNT_W'(PATTERN_LEN)) begin
              count <= count_inc;
              if (q_item.byte_value == STAR_BYTE && start[count]) begin
                start[count_inc] <= 1'b1;
              end
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          KIND_TEXT: begin
            active    <= adv;
            text_open <= 1'b1;
          end
          KIND_TEXT_LAST: begin
            active       <= adv;
            text_open    <= 1'b0;
            out_matched  <= adv[count];
            out_overflow <= overflow_seen;
          end
          KIND_EVAL_EMPTY: begin
            active       <= start;
            text_open    <= 1'b0;
            out_matched  <= start[count];
            out_overflow <= overflow_seen;
          end
          default: begin
            text_open <= 1'b0;
          end
        endcase
      end
    end
  end

  `WSM_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(PATTERN_LEN))
  `WSM_ASSERT_ALWAYS(a_active_in_range, (active & ~upto_count) == '0)
  `WSM_ASSERT_ALWAYS(a_overflow_full, !overflow_seen || count == CNT_W'(PATTERN_LEN))
  `WSM_ASSERT_NEXT(a_clear_empties, take && q_item.kind == KIND_CLEAR,
                   count == '0 && !overflow_seen && !text_open)

endmodule

@@ src/wildcard_star_matcher.sv @@
// Anchored glob matcher where '*' matches any run of bytes, empty included. Load the pattern
// one byte per transaction (up to 32 positions; extra bytes are dropped and flagged), then
// stream text bytes with tlast on the final one; a result with the match bit leaves after each
// text and after an empty-text evaluation. The block takes one transaction per clock while the
// queue has room: a four-entry queue decouples the input from the matcher, which updates every
// pattern position at once on each text byte, folding star closure into one 33-bit add. An input
// sits in a queue entry, then in the result register, before it leaves. ignore_case (address 0,
// reset 1) folds A-Z to lower case on both sides; write it only while no text is in flight.
module wildcard_star_matcher
  import wsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        s_tlast,   // is_last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] matched, [1] pattern_overflow, [7:2] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic  ignore_case;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;
  logic  res_matched;
  logic  res_overflow;

  assign pready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_case <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_IGNORE_CASE) begin
      ignore_case <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_IGNORE_CASE) ? {31'd0, ignore_case} : 32'd0;

  wsm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tuser),
    .byte_value (s_tdata),
    .is_last    (s_tlast),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  wsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .ignore_case  (ignore_case),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_matched  (res_matched),
    .out_overflow (res_overflow)
  );

  assign m_tdata = {6'd0, res_overflow, res_matched};

endmodule
